### hw/rtl/lr1pe_pkg.sv
// ----------------------------------------------------------------------------
// lr1pe_pkg
// Shared codes, widths and controller/datapath interface types for the
// LR(1) parse engine.
// ----------------------------------------------------------------------------
package lr1pe_pkg;

    localparam int NUM_STATES  = 256;
    localparam int NUM_SYMBOLS = 64;
    localparam int NUM_RULES   = 256;
    localparam int STACK_DEPTH = 256;

    localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int STK_AW    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W    = 6;

    localparam logic [ITER_W-1:0] MAX_REDUCTIONS = 6'd63;

    localparam logic [2:0] OP_LOAD_ACTION = 3'd0;
    localparam logic [2:0] OP_LOAD_GOTO   = 3'd1;
    localparam logic [2:0] OP_LOAD_RULE   = 3'd2;
    localparam logic [2:0] OP_TOKEN       = 3'd3;
    localparam logic [2:0] OP_RESTART     = 3'd4;

    localparam logic [1:0] ACT_REJECT = 2'd0;
    localparam logic [1:0] ACT_SHIFT  = 2'd1;
    localparam logic [1:0] ACT_REDUCE = 2'd2;
    localparam logic [1:0] ACT_ACCEPT = 2'd3;

    localparam logic [2:0] EV_REDUCE   = 3'd0;
    localparam logic [2:0] EV_SHIFT    = 3'd1;
    localparam logic [2:0] EV_ACCEPT   = 3'd2;
    localparam logic [2:0] EV_ERROR    = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;
    localparam logic [2:0] EV_DONE     = 3'd5;

    localparam logic [1:0] HALT_RUN    = 2'd0;
    localparam logic [1:0] HALT_ACCEPT = 2'd1;
    localparam logic [1:0] HALT_ERROR  = 2'd2;

    localparam logic [1:0] SEL_TOP    = 2'd0;
    localparam logic [1:0] SEL_TARGET = 2'd1;
    localparam logic [1:0] SEL_GOTO   = 2'd2;
    localparam logic [1:0] SEL_POP    = 2'd3;

    localparam logic CFG_STACK_LIMIT = 1'b0;
    localparam logic CFG_LOG_ENABLE  = 1'b1;

    typedef struct packed {
        logic       load_act;
        logic       load_goto;
        logic       load_rule;
        logic       restart;
        logic       latch_token;
        logic       act_rd;
        logic [1:0] cand_sel;
        logic       rule_rd;
        logic       pop_rd;
        logic       acc_rd;
        logic       take_pop;
        logic       goto_rd;
        logic       push_shift;
        logic       push_goto;
        logic       emit;
        logic [2:0] kind;
        logic [1:0] st_sel;
        logic       rule_en;
        logic       term_en;
        logic       last;
        logic       halt_wr;
        logic [1:0] halt_val;
    } lr1pe_cmd_t;

    typedef struct packed {
        logic       halted;
        logic [1:0] act_type;
        logic [1:0] cnt_m1;
        logic       at_limit;
        logic       depth_gt1;
        logic       rhs_ge_depth;
        logic       log_en;
        logic       out_free;
    } lr1pe_status_t;

endpackage

### hw/rtl/lr1pe_ram.sv
// ----------------------------------------------------------------------------
// lr1pe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lr1pe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lr1pe_datapath.sv
// ----------------------------------------------------------------------------
// lr1pe_datapath
// Parse tables, state stack, top/depth/halt registers, configuration and
// the output word register.
// ----------------------------------------------------------------------------
module lr1pe_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lr1pe_pkg::lr1pe_cmd_t  cmd,
    output lr1pe_pkg::lr1pe_status_t st,
    input  logic [7:0]             row_index,
    input  logic [5:0]             column_index,
    input  logic [9:0]             entry_word,
    input  logic [2:0]             candidate_count,
    input  logic [5:0]             candidate_a,
    input  logic [5:0]             candidate_b,
    input  logic [5:0]             candidate_c,
    input  logic [5:0]             candidate_d,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [8:0]             cfg_wdata,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             event_kind,
    output logic [7:0]             rule_number,
    output logic [7:0]             new_state,
    output logic [5:0]             chosen_terminal,
    output logic                   last_of_run
);

    localparam int DW = lr1pe_pkg::DEPTH_W;
    localparam int AW = lr1pe_pkg::STK_AW;

    logic [7:0]    top_reg;
    logic [DW-1:0] depth_reg;
    logic [1:0]    halt_reg;
    logic [8:0]    limit_reg;
    logic          log_reg;
    logic [5:0]    cand_reg [4];
    logic [1:0]    cnt_m1_reg;
    logic [5:0]    code_reg;
    logic [7:0]    target_reg;
    logic [5:0]    lhs_reg;
    logic          pop_zero_reg;

    logic          out_valid_reg;
    logic [2:0]    kind_reg;
    logic [7:0]    rule_reg;
    logic [7:0]    state_reg;
    logic [5:0]    term_reg;
    logic          last_reg;

    logic [9:0]    act_rdata;
    logic [7:0]    goto_rdata;
    logic [9:0]    rule_rdata;
    logic [7:0]    stk_rdata;

    logic [lr1pe_pkg::TBL_AW-1:0] tbl_waddr;
    logic [lr1pe_pkg::TBL_AW-1:0] act_raddr;
    logic [lr1pe_pkg::TBL_AW-1:0] goto_raddr;
    logic [AW-1:0]  stk_waddr;
    logic [AW-1:0]  stk_raddr;
    logic [7:0]     stk_wdata;
    logic [7:0]     pop_value;
    logic [DW-1:0]  eff_limit;
    logic [DW-1:0]  rhs_ext;
    logic [DW-1:0]  depth_popped;
    logic [DW-1:0]  pop_addr;
    logic [DW-1:0]  acc_addr;
    logic [5:0]     cand_cur;
    logic [7:0]     emit_state;
    logic           out_free;

    assign tbl_waddr  = {row_index, column_index};
    assign cand_cur   = cand_reg[cmd.cand_sel];
    assign act_raddr  = {top_reg, cand_cur};
    assign pop_value  = pop_zero_reg ? 8'd0 : stk_rdata;
    assign goto_raddr = {pop_value, lhs_reg};

    assign rhs_ext      = DW'(rule_rdata[3:0]);
    assign depth_popped = depth_reg - rhs_ext;
    assign pop_addr     = depth_popped - DW'(1);
    assign acc_addr     = depth_reg - DW'(2);
    assign stk_raddr    = cmd.acc_rd ? acc_addr[AW-1:0] : pop_addr[AW-1:0];
    assign stk_waddr    = depth_reg[AW-1:0];
    assign stk_wdata    = cmd.push_goto ? goto_rdata : act_rdata[7:0];

    always_comb
    begin
        if (limit_reg == 9'd0)
        begin
            eff_limit = DW'(1);
        end
        else if (DW'(limit_reg) > DW'(lr1pe_pkg::STACK_DEPTH))
        begin
            eff_limit = DW'(lr1pe_pkg::STACK_DEPTH);
        end
        else
        begin
            eff_limit = DW'(limit_reg);
        end
    end

    always_comb
    begin
        case (cmd.st_sel)
            lr1pe_pkg::SEL_TARGET: emit_state = act_rdata[7:0];
            lr1pe_pkg::SEL_GOTO:   emit_state = goto_rdata;
            lr1pe_pkg::SEL_POP:    emit_state = pop_value;
            default:               emit_state = top_reg;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    assign st.halted       = (halt_reg != lr1pe_pkg::HALT_RUN);
    assign st.act_type     = act_rdata[9:8];
    assign st.cnt_m1       = cnt_m1_reg;
    assign st.at_limit     = (depth_reg >= eff_limit);
    assign st.depth_gt1    = (depth_reg > DW'(1));
    assign st.rhs_ge_depth = (rhs_ext >= depth_reg);
    assign st.log_en       = log_reg;
    assign st.out_free     = out_free;

    lr1pe_ram #(.WIDTH(10), .DEPTH(lr1pe_pkg::TBL_DEPTH)) u_action_ram (
        .clk(clk), .we(cmd.load_act), .waddr(tbl_waddr), .wdata(entry_word),
        .re(cmd.act_rd), .raddr(act_raddr), .rdata(act_rdata)
    );

    lr1pe_ram #(.WIDTH(8), .DEPTH(lr1pe_pkg::TBL_DEPTH)) u_goto_ram (
        .clk(clk), .we(cmd.load_goto), .waddr(tbl_waddr), .wdata(entry_word[7:0]),
        .re(cmd.goto_rd), .raddr(goto_raddr), .rdata(goto_rdata)
    );

    lr1pe_ram #(.WIDTH(10), .DEPTH(lr1pe_pkg::NUM_RULES)) u_rule_ram (
        .clk(clk), .we(cmd.load_rule), .waddr(row_index), .wdata(entry_word),
        .re(cmd.rule_rd), .raddr(act_rdata[7:0]), .rdata(rule_rdata)
    );

    lr1pe_ram #(.WIDTH(8), .DEPTH(lr1pe_pkg::STACK_DEPTH)) u_stack_ram (
        .clk(clk), .we(cmd.push_shift || cmd.push_goto), .waddr(stk_waddr),
        .wdata(stk_wdata), .re(cmd.pop_rd || cmd.acc_rd), .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= 8'd0;
            depth_reg     <= DW'(1);
            halt_reg      <= lr1pe_pkg::HALT_RUN;
            limit_reg     <= 9'd256;
            log_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lr1pe_pkg::CFG_STACK_LIMIT: limit_reg <= cfg_wdata;
                    lr1pe_pkg::CFG_LOG_ENABLE:  log_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.restart)
            begin
                top_reg   <= 8'd0;
                depth_reg <= DW'(1);
                halt_reg  <= lr1pe_pkg::HALT_RUN;
            end
            if (cmd.push_shift)
            begin
                top_reg   <= act_rdata[7:0];
                depth_reg <= depth_reg + DW'(1);
            end
            if (cmd.push_goto)
            begin
                top_reg   <= goto_rdata;
                depth_reg <= depth_reg + DW'(1);
            end
            if (cmd.acc_rd)
            begin
                depth_reg <= depth_reg - DW'(1);
            end
            if (cmd.pop_rd)
            begin
                depth_reg <= depth_popped;
            end
            if (cmd.take_pop)
            begin
                top_reg <= pop_value;
            end
            if (cmd.halt_wr)
            begin
                halt_reg <= cmd.halt_val;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_token)
        begin
            cand_reg[0] <= candidate_a;
            cand_reg[1] <= candidate_b;
            cand_reg[2] <= candidate_c;
            cand_reg[3] <= candidate_d;
            if (candidate_count == 3'd0)
            begin
                cnt_m1_reg <= 2'd0;
            end
            else if (candidate_count > 3'd4)
            begin
                cnt_m1_reg <= 2'd3;
            end
            else
            begin
                cnt_m1_reg <= 2'(candidate_count - 3'd1);
            end
        end
        if (cmd.act_rd)
        begin
            code_reg <= cand_cur;
        end
        if (cmd.rule_rd)
        begin
            target_reg <= act_rdata[7:0];
        end
        if (cmd.pop_rd)
        begin
            lhs_reg      <= rule_rdata[9:4];
            pop_zero_reg <= (pop_addr == DW'(0));
        end
        if (cmd.acc_rd)
        begin
            pop_zero_reg <= (acc_addr == DW'(0));
        end
        if (cmd.emit)
        begin
            kind_reg  <= cmd.kind;
            rule_reg  <= cmd.rule_en ? target_reg : 8'd0;
            state_reg <= emit_state;
            term_reg  <= cmd.term_en ? code_reg : 6'd0;
            last_reg  <= cmd.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = kind_reg;
    assign rule_number     = rule_reg;
    assign new_state       = state_reg;
    assign chosen_terminal = term_reg;
    assign last_of_run     = last_reg;

    a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg != DW'(0))
        else $error("stack depth reached zero");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(lr1pe_pkg::STACK_DEPTH))
        else $error("stack depth above capacity");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_shift || cmd.push_goto) |-> !st.at_limit)
        else $error("push at stack limit");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("output word overwritten");

endmodule

### hw/rtl/lr1pe_ctrl.sv
// ----------------------------------------------------------------------------
// lr1pe_ctrl
// Sequencer for the parse engine: candidate lookup, reduction loop, shift,
// accept and error handling.
// ----------------------------------------------------------------------------
module lr1pe_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               opcode,
    input  lr1pe_pkg::lr1pe_status_t st,
    output lr1pe_pkg::lr1pe_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_ACT,
        S_ACC,
        S_RULE,
        S_POP,
        S_GOTO
    } state_t;

    state_t                          state_reg, state_next;
    logic [1:0]                      idx_reg, idx_next;
    logic [lr1pe_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic                            in_fire;

    assign in_ready = (state_reg == S_IDLE) && st.out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        cmd.term_en = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (opcode)
                        lr1pe_pkg::OP_LOAD_ACTION: cmd.load_act  = 1'b1;
                        lr1pe_pkg::OP_LOAD_GOTO:   cmd.load_goto = 1'b1;
                        lr1pe_pkg::OP_LOAD_RULE:   cmd.load_rule = 1'b1;
                        lr1pe_pkg::OP_RESTART:     cmd.restart   = 1'b1;
                        lr1pe_pkg::OP_TOKEN:
                        begin
                            if (st.halted)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.kind    = lr1pe_pkg::EV_DONE;
                                cmd.st_sel  = lr1pe_pkg::SEL_TOP;
                                cmd.term_en = 1'b0;
                                cmd.last    = 1'b1;
                            end
                            else
                            begin
                                cmd.latch_token = 1'b1;
                                idx_next   = 2'd0;
                                iter_next  = '0;
                                state_next = S_LOOKUP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                cmd.act_rd   = 1'b1;
                cmd.cand_sel = idx_reg;
                state_next   = S_ACT;
            end
            S_ACT:
            begin
                unique case (st.act_type)
                    lr1pe_pkg::ACT_REJECT:
                    begin
                        if (idx_reg != st.cnt_m1)
                        begin
                            idx_next   = idx_reg + 2'd1;
                            state_next = S_LOOKUP;
                        end
                        else if (st.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.kind     = lr1pe_pkg::EV_ERROR;
                            cmd.st_sel   = lr1pe_pkg::SEL_TOP;
                            cmd.last     = 1'b1;
                            cmd.halt_wr  = 1'b1;
                            cmd.halt_val = lr1pe_pkg::HALT_ERROR;
                            state_next   = S_IDLE;
                        end
                    end
                    lr1pe_pkg::ACT_SHIFT:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                            if (st.at_limit)
                            begin
                                cmd.kind     = lr1pe_pkg::EV_OVERFLOW;
                                cmd.st_sel   = lr1pe_pkg::SEL_TOP;
                                cmd.halt_wr  = 1'b1;
                                cmd.halt_val = lr1pe_pkg::HALT_ERROR;
                            end
                            else
                            begin
                                cmd.kind       = lr1pe_pkg::EV_SHIFT;
                                cmd.st_sel     = lr1pe_pkg::SEL_TARGET;
                                cmd.push_shift = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    lr1pe_pkg::ACT_ACCEPT:
                    begin
                        if (st.depth_gt1)
                        begin
                            cmd.acc_rd = 1'b1;
                            state_next = S_ACC;
                        end
                        else if (st.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.kind     = lr1pe_pkg::EV_ACCEPT;
                            cmd.st_sel   = lr1pe_pkg::SEL_TOP;
                            cmd.last     = 1'b1;
                            cmd.halt_wr  = 1'b1;
                            cmd.halt_val = lr1pe_pkg::HALT_ACCEPT;
                            state_next   = S_IDLE;
                        end
                    end
                    lr1pe_pkg::ACT_REDUCE:
                    begin
                        if (iter_reg == lr1pe_pkg::MAX_REDUCTIONS)
                        begin
                            if (st.out_free)
                            begin
                                cmd.emit     = 1'b1;
                                cmd.kind     = lr1pe_pkg::EV_ERROR;
                                cmd.st_sel   = lr1pe_pkg::SEL_TOP;
                                cmd.last     = 1'b1;
                                cmd.halt_wr  = 1'b1;
                                cmd.halt_val = lr1pe_pkg::HALT_ERROR;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rule_rd = 1'b1;
                            iter_next   = iter_reg + 1'b1;
                            state_next  = S_RULE;
                        end
                    end
                    default: ;
                endcase
            end
            S_ACC:
            begin
                if (st.out_free)
                begin
                    cmd.take_pop = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.kind     = lr1pe_pkg::EV_ACCEPT;
                    cmd.st_sel   = lr1pe_pkg::SEL_POP;
                    cmd.last     = 1'b1;
                    cmd.halt_wr  = 1'b1;
                    cmd.halt_val = lr1pe_pkg::HALT_ACCEPT;
                    state_next   = S_IDLE;
                end
            end
            S_RULE:
            begin
                if (!st.rhs_ge_depth)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP;
                end
                else if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = lr1pe_pkg::EV_ERROR;
                    cmd.st_sel   = lr1pe_pkg::SEL_TOP;
                    cmd.rule_en  = 1'b1;
                    cmd.last     = 1'b1;
                    cmd.halt_wr  = 1'b1;
                    cmd.halt_val = lr1pe_pkg::HALT_ERROR;
                    state_next   = S_IDLE;
                end
            end
            S_POP:
            begin
                cmd.take_pop = 1'b1;
                cmd.goto_rd  = 1'b1;
                state_next   = S_GOTO;
            end
            S_GOTO:
            begin
                if (st.at_limit)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.kind     = lr1pe_pkg::EV_OVERFLOW;
                        cmd.st_sel   = lr1pe_pkg::SEL_TOP;
                        cmd.rule_en  = 1'b1;
                        cmd.last     = 1'b1;
                        cmd.halt_wr  = 1'b1;
                        cmd.halt_val = lr1pe_pkg::HALT_ERROR;
                        state_next   = S_IDLE;
                    end
                end
                else if (!st.log_en || st.out_free)
                begin
                    cmd.push_goto = 1'b1;
                    cmd.emit      = st.log_en;
                    cmd.kind      = lr1pe_pkg::EV_REDUCE;
                    cmd.st_sel    = lr1pe_pkg::SEL_GOTO;
                    cmd.rule_en   = 1'b1;
                    idx_next      = 2'd0;
                    state_next    = S_LOOKUP;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            iter_reg  <= iter_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("input taken outside idle");

    a_lookup_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |=> (state_reg == S_ACT))
        else $error("lookup not followed by action decode");

    a_reduce_nolast: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.kind == lr1pe_pkg::EV_REDUCE) |-> !cmd.last)
        else $error("reduce word marked last");

endmodule

### hw/rtl/lr1_parse_engine_top.sv
// ----------------------------------------------------------------------------
// lr1_parse_engine_top
// Table-driven LR(1) shift-reduce parse engine with streaming ports.
// ----------------------------------------------------------------------------
// Loads and restarts are done as they are taken. The action, goto, rule and
// stack RAMs each give one registered read per cycle. A token is latched, each
// candidate is looked up, each reduction reads the rule, stack and goto RAMs,
// and a popping accept reads the stack again. One token is worked on at a time.
// Reset empties the stack to state 0, clears halt, and sets stack_limit 256
// and reduction_log_enable 1; table contents are undefined until loaded.
module lr1_parse_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row_index, column_index, entry_word, candidate_count,
    // candidate_a, candidate_b, candidate_c, candidate_d
    input  logic [55:0] s_axis_tdata,
    // opcode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rule_number, new_state, chosen_terminal
    output logic [23:0] m_axis_tdata,
    // event_kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_wdata
);

    lr1pe_pkg::lr1pe_cmd_t    cmd;
    lr1pe_pkg::lr1pe_status_t st;
    logic [7:0] rule_number;
    logic [7:0] new_state;
    logic [5:0] chosen_terminal;

    lr1pe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .opcode   (s_axis_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    lr1pe_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .row_index       (s_axis_tdata[7:0]),
        .column_index    (s_axis_tdata[13:8]),
        .entry_word      (s_axis_tdata[23:14]),
        .candidate_count (s_axis_tdata[26:24]),
        .candidate_a     (s_axis_tdata[32:27]),
        .candidate_b     (s_axis_tdata[38:33]),
        .candidate_c     (s_axis_tdata[44:39]),
        .candidate_d     (s_axis_tdata[50:45]),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .event_kind      (m_axis_tuser),
        .rule_number     (rule_number),
        .new_state       (new_state),
        .chosen_terminal (chosen_terminal),
        .last_of_run     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, chosen_terminal, new_state, rule_number};

endmodule

### bench/lr1_parse_engine_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lr1_parse_engine_top_test
// Self-checking bench for the LR(1) parse engine. Table contents are filled
// on demand as each token is planned, so a token never reads an unloaded
// entry. A shadow parser predicts every event word, and the output stream is
// compared against it under random idling and back-pressure and under several
// register settings.
// ----------------------------------------------------------------------------
module lr1_parse_engine_top_test;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] rule;
        logic [7:0] state;
        logic [5:0] term;
        logic       last;
    } parse_event_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_wdata;

    // opcode in the low 3 bits, the data word above it
    logic [58:0]  word_q[$];
    parse_event_t event_q[$];

    logic [9:0] act_mem[lr1pe_pkg::TBL_DEPTH];
    bit         act_set[lr1pe_pkg::TBL_DEPTH];
    logic [7:0] goto_mem[lr1pe_pkg::TBL_DEPTH];
    bit         goto_set[lr1pe_pkg::TBL_DEPTH];
    logic [9:0] rule_mem[lr1pe_pkg::NUM_RULES];
    bit         rule_set[lr1pe_pkg::NUM_RULES];
    logic [7:0] stk[lr1pe_pkg::STACK_DEPTH];
    int         depth;
    logic [1:0] halt;
    int         limit_reg;
    bit         log_en;

    int  fails;
    int  in_idle;
    int  out_idle;
    bit  hold_off;
    bit  no_idle;

    lr1_parse_engine_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [58:0] pack_word(logic [2:0] op, logic [7:0] row,
                                              logic [5:0] col, logic [9:0] entry,
                                              logic [2:0] cnt, logic [5:0] a,
                                              logic [5:0] b, logic [5:0] c,
                                              logic [5:0] d);
        return {5'b00000, d, c, b, a, cnt, entry, col, row, op};
    endfunction

    function automatic void queue_load(logic [2:0] op, int row, int col, int entry);
        word_q.push_back(pack_word(op, row[7:0], col[5:0], entry[9:0], 3'd0,
                                   6'd0, 6'd0, 6'd0, 6'd0));
        case (op)
            lr1pe_pkg::OP_LOAD_ACTION:
            begin
                act_mem[row * lr1pe_pkg::NUM_SYMBOLS + col] = entry[9:0];
                act_set[row * lr1pe_pkg::NUM_SYMBOLS + col] = 1'b1;
            end
            lr1pe_pkg::OP_LOAD_GOTO:
            begin
                goto_mem[row * lr1pe_pkg::NUM_SYMBOLS + col] = entry[7:0];
                goto_set[row * lr1pe_pkg::NUM_SYMBOLS + col] = 1'b1;
            end
            lr1pe_pkg::OP_LOAD_RULE:
            begin
                rule_mem[row] = entry[9:0];
                rule_set[row] = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void queue_restart();
        word_q.push_back(pack_word(lr1pe_pkg::OP_RESTART, 8'($urandom), 6'($urandom),
                                   10'($urandom), 3'($urandom), 6'($urandom),
                                   6'($urandom), 6'($urandom), 6'($urandom)));
        foreach (stk[i])
            stk[i] = 8'd0;
        depth = 1;
        halt  = lr1pe_pkg::HALT_RUN;
    endfunction

    // Walk one token through the shadow parser; report the first unloaded read.
    function automatic void predict_token(input logic [2:0] cnt_in,
                                          input logic [5:0] cand[4],
                                          input bit commit,
                                          output int miss_kind,
                                          output int miss_addr);
        logic [7:0]   ls[lr1pe_pkg::STACK_DEPTH];
        int           ld;
        logic [1:0]   lh;
        int           cnt;
        int           lim;
        int           iter;
        int           top;
        int           code;
        int           adr;
        logic [1:0]   typ;
        logic [7:0]   tgt;
        int           rhs;
        int           lhs;
        logic [7:0]   g;
        parse_event_t ev;
        parse_event_t evs[$];

        ls        = stk;
        ld        = depth;
        lh        = halt;
        miss_kind = 0;
        miss_addr = 0;
        iter      = 0;
        cnt       = (cnt_in == 0) ? 1 : ((cnt_in > 4) ? 4 : cnt_in);
        lim       = (limit_reg == 0) ? 1 :
                    ((limit_reg > lr1pe_pkg::STACK_DEPTH) ? lr1pe_pkg::STACK_DEPTH
                                                          : limit_reg);

        if (lh != lr1pe_pkg::HALT_RUN)
        begin
            ev = '{lr1pe_pkg::EV_DONE, 8'd0, ls[ld-1], 6'd0, 1'b0};
            evs.push_back(ev);
        end
        else
        begin
            forever
            begin
                top = ls[ld-1];
                typ = lr1pe_pkg::ACT_REJECT;
                tgt = 8'd0;
                code = 0;
                for (int i = 0; i < cnt; i++)
                begin
                    code = cand[i];
                    adr  = top * lr1pe_pkg::NUM_SYMBOLS + code;
                    if (!act_set[adr])
                    begin
                        miss_kind = 1;
                        miss_addr = adr;
                        return;
                    end
                    typ = act_mem[adr][9:8];
                    tgt = act_mem[adr][7:0];
                    if (typ != lr1pe_pkg::ACT_REJECT)
                        break;
                end
                if (typ == lr1pe_pkg::ACT_REJECT)
                begin
                    ev = '{lr1pe_pkg::EV_ERROR, 8'd0, top[7:0], code[5:0], 1'b0};
                    evs.push_back(ev);
                    lh = lr1pe_pkg::HALT_ERROR;
                    break;
                end
                if (typ == lr1pe_pkg::ACT_SHIFT)
                begin
                    if (ld >= lim)
                    begin
                        ev = '{lr1pe_pkg::EV_OVERFLOW, 8'd0, top[7:0], code[5:0], 1'b0};
                        evs.push_back(ev);
                        lh = lr1pe_pkg::HALT_ERROR;
                    end
                    else
                    begin
                        ls[ld] = tgt;
                        ld++;
                        ev = '{lr1pe_pkg::EV_SHIFT, 8'd0, tgt, code[5:0], 1'b0};
                        evs.push_back(ev);
                    end
                    break;
                end
                if (typ == lr1pe_pkg::ACT_ACCEPT)
                begin
                    if (ld > 1)
                        ld--;
                    ev = '{lr1pe_pkg::EV_ACCEPT, 8'd0, ls[ld-1], code[5:0], 1'b0};
                    evs.push_back(ev);
                    lh = lr1pe_pkg::HALT_ACCEPT;
                    break;
                end
                if (iter >= lr1pe_pkg::MAX_REDUCTIONS)
                begin
                    ev = '{lr1pe_pkg::EV_ERROR, 8'd0, top[7:0], code[5:0], 1'b0};
                    evs.push_back(ev);
                    lh = lr1pe_pkg::HALT_ERROR;
                    break;
                end
                iter++;
                if (!rule_set[tgt])
                begin
                    miss_kind = 2;
                    miss_addr = tgt;
                    return;
                end
                rhs = rule_mem[tgt][3:0];
                lhs = rule_mem[tgt][9:4];
                if (rhs >= ld)
                begin
                    ev = '{lr1pe_pkg::EV_ERROR, tgt, top[7:0], code[5:0], 1'b0};
                    evs.push_back(ev);
                    lh = lr1pe_pkg::HALT_ERROR;
                    break;
                end
                ld  = ld - rhs;
                top = ls[ld-1];
                adr = top * lr1pe_pkg::NUM_SYMBOLS + lhs;
                if (!goto_set[adr])
                begin
                    miss_kind = 3;
                    miss_addr = adr;
                    return;
                end
                g = goto_mem[adr];
                if (ld >= lim)
                begin
                    ev = '{lr1pe_pkg::EV_OVERFLOW, tgt, top[7:0], code[5:0], 1'b0};
                    evs.push_back(ev);
                    lh = lr1pe_pkg::HALT_ERROR;
                    break;
                end
                ls[ld] = g;
                ld++;
                if (log_en)
                begin
                    ev = '{lr1pe_pkg::EV_REDUCE, tgt, g, code[5:0], 1'b0};
                    evs.push_back(ev);
                end
            end
        end
        if (commit)
        begin
            evs[evs.size()-1].last = 1'b1;
            foreach (evs[i])
                event_q.push_back(evs[i]);
            stk   = ls;
            depth = ld;
            halt  = lh;
        end
    endfunction

    function automatic int pick_state();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    endfunction

    function automatic void fill_entry(int kind, int adr);
        int r;
        int tgt;
        r = $urandom_range(0, 19);
        if (kind == 1)
        begin
            if (r < 4)
                tgt = {lr1pe_pkg::ACT_REJECT, 8'($urandom)};
            else if (r < 11)
                tgt = {lr1pe_pkg::ACT_SHIFT, 8'(pick_state())};
            else if (r < 18)
                tgt = {lr1pe_pkg::ACT_REDUCE, 8'(pick_state())};
            else
                tgt = {lr1pe_pkg::ACT_ACCEPT, 8'($urandom)};
            queue_load(lr1pe_pkg::OP_LOAD_ACTION, adr / lr1pe_pkg::NUM_SYMBOLS,
                       adr % lr1pe_pkg::NUM_SYMBOLS, tgt);
        end
        else if (kind == 2)
        begin
            tgt = {6'($urandom_range(0, 63)),
                   4'((r < 16) ? $urandom_range(0, 3) : $urandom_range(0, 15))};
            queue_load(lr1pe_pkg::OP_LOAD_RULE, adr, 0, tgt);
        end
        else
            queue_load(lr1pe_pkg::OP_LOAD_GOTO, adr / lr1pe_pkg::NUM_SYMBOLS,
                       adr % lr1pe_pkg::NUM_SYMBOLS, pick_state());
    endfunction

    function automatic void queue_token(logic [2:0] cnt, logic [5:0] a, logic [5:0] b,
                                        logic [5:0] c, logic [5:0] d);
        logic [5:0] cand[4];
        int mk;
        int ma;
        cand = '{a, b, c, d};
        forever
        begin
            predict_token(cnt, cand, 1'b0, mk, ma);
            if (mk == 0)
                break;
            fill_entry(mk, ma);
        end
        predict_token(cnt, cand, 1'b1, mk, ma);
        word_q.push_back(pack_word(lr1pe_pkg::OP_TOKEN, 8'($urandom), 6'($urandom),
                                   10'($urandom), cnt, a, b, c, d));
    endfunction

    function automatic logic [5:0] pick_term();
        return 6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, 7));
    endfunction

    function automatic void queue_random(int count);
        int r;
        logic [2:0] cnt;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (halt != lr1pe_pkg::HALT_RUN && r < 60)
                queue_restart();
            else if (r < 72)
            begin
                cnt = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                     : $urandom_range(1, 4));
                queue_token(cnt, pick_term(), pick_term(), pick_term(), pick_term());
            end
            else if (r < 80)
                queue_restart();
            else if (r < 94)
                queue_load(3'($urandom_range(lr1pe_pkg::OP_LOAD_ACTION,
                                             lr1pe_pkg::OP_LOAD_RULE)),
                           $urandom_range(0, 255), $urandom_range(0, 63),
                           $urandom_range(0, 1023));
            else
                word_q.push_back({5'b00000, 51'($urandom) << 20 ^ 51'($urandom),
                                  3'($urandom_range(5, 7))});
            if (k % 4 == 3 && $urandom_range(0, 1) == 0)
                queue_token(3'($urandom_range(1, 4)), pick_term(), pick_term(),
                            pick_term(), pick_term());
        end
    endfunction

    task automatic settle();
        while (word_q.size() != 0 || s_axis_tvalid || event_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[8:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == lr1pe_pkg::CFG_STACK_LIMIT)
            limit_reg = value;
        else
            log_en = value[0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            in_idle       <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                void'(word_q.pop_front());
            if (in_idle > 0)
            begin
                in_idle       <= in_idle - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (word_q.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= word_q[0][2:0];
                s_axis_tdata  <= word_q[0][58:3];
                if (!no_idle && $urandom_range(0, 7) == 0)
                    in_idle <= $urandom_range(1, 6);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        parse_event_t exp_ev;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_idle      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (event_q.size() == 0)
                begin
                    $error("unexpected event word kind=%0d", m_axis_tuser);
                    fails++;
                end
                else
                begin
                    exp_ev = event_q.pop_front();
                    if (m_axis_tuser !== exp_ev.kind)
                    begin
                        $error("event_kind expected %0d got %0d", exp_ev.kind, m_axis_tuser);
                        fails++;
                    end
                    if (m_axis_tdata[7:0] !== exp_ev.rule)
                    begin
                        $error("rule_number expected %0d got %0d", exp_ev.rule,
                               m_axis_tdata[7:0]);
                        fails++;
                    end
                    if (m_axis_tdata[15:8] !== exp_ev.state)
                    begin
                        $error("new_state expected %0d got %0d", exp_ev.state,
                               m_axis_tdata[15:8]);
                        fails++;
                    end
                    if (m_axis_tdata[21:16] !== exp_ev.term)
                    begin
                        $error("chosen_terminal expected %0d got %0d", exp_ev.term,
                               m_axis_tdata[21:16]);
                        fails++;
                    end
                    if (m_axis_tlast !== exp_ev.last)
                    begin
                        $error("last_of_run expected %0d got %0d", exp_ev.last,
                               m_axis_tlast);
                        fails++;
                    end
                end
            end
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (out_idle > 0)
            begin
                out_idle      <= out_idle - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 6) == 0)
                    out_idle <= $urandom_range(1, 6);
            end
        end
    end

    initial
    begin
        hold_off = 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (500) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        fails     = 0;
        no_idle   = 1'b0;
        foreach (act_set[i])
        begin
            act_set[i]  = 1'b0;
            goto_set[i] = 1'b0;
        end
        foreach (rule_set[i])
            rule_set[i] = 1'b0;
        foreach (stk[i])
            stk[i] = 8'd0;
        depth     = 1;
        halt      = lr1pe_pkg::HALT_RUN;
        limit_reg = 256;
        log_en    = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_load(lr1pe_pkg::OP_LOAD_ACTION, 0, 63, {lr1pe_pkg::ACT_SHIFT, 8'd255});
        queue_token(3'd1, 6'd63, 6'd0, 6'd0, 6'd0);
        queue_load(lr1pe_pkg::OP_LOAD_ACTION, 255, 0, {lr1pe_pkg::ACT_REJECT, 8'd0});
        queue_load(lr1pe_pkg::OP_LOAD_ACTION, 255, 1, {lr1pe_pkg::ACT_ACCEPT, 8'd0});
        queue_token(3'd4, 6'd0, 6'd1, 6'd63, 6'd63);
        queue_token(3'd2, 6'd0, 6'd1, 6'd0, 6'd0);
        queue_restart();
        word_q.push_back({5'b00000, {51{1'b1}}, 3'd7});
        queue_load(lr1pe_pkg::OP_LOAD_RULE, 255, 0, 1023);
        queue_load(lr1pe_pkg::OP_LOAD_ACTION, 0, 5, {lr1pe_pkg::ACT_REDUCE, 8'd255});
        queue_token(3'd1, 6'd5, 6'd0, 6'd0, 6'd0);
        queue_restart();
        queue_load(lr1pe_pkg::OP_LOAD_RULE, 0, 0, 0);
        queue_load(lr1pe_pkg::OP_LOAD_ACTION, 0, 6, {lr1pe_pkg::ACT_REDUCE, 8'd0});
        queue_load(lr1pe_pkg::OP_LOAD_GOTO, 0, 0, 0);
        queue_token(3'd1, 6'd6, 6'd0, 6'd0, 6'd0);
        queue_restart();
        queue_load(lr1pe_pkg::OP_LOAD_ACTION, 0, 4, {lr1pe_pkg::ACT_REJECT, 8'd0});
        queue_token(3'd0, 6'd4, 6'd63, 6'd63, 6'd63);
        queue_restart();
        queue_random(25);
        settle();

        write_reg(lr1pe_pkg::CFG_STACK_LIMIT, 0);
        queue_restart();
        queue_random(20);
        settle();

        write_reg(lr1pe_pkg::CFG_STACK_LIMIT, 2);
        write_reg(lr1pe_pkg::CFG_LOG_ENABLE, 0);
        queue_restart();
        queue_token(3'd1, 6'd6, 6'd0, 6'd0, 6'd0);
        queue_restart();
        queue_random(20);
        settle();

        write_reg(lr1pe_pkg::CFG_STACK_LIMIT, 511);
        write_reg(lr1pe_pkg::CFG_LOG_ENABLE, 1);
        queue_restart();
        queue_random(20);
        settle();

        write_reg(lr1pe_pkg::CFG_STACK_LIMIT, 5);
        write_reg(lr1pe_pkg::CFG_LOG_ENABLE, 0);
        queue_restart();
        queue_random(20);
        settle();

        write_reg(lr1pe_pkg::CFG_STACK_LIMIT, 256);
        write_reg(lr1pe_pkg::CFG_LOG_ENABLE, 1);
        no_idle = 1'b1;
        queue_restart();
        queue_random(20);
        settle();

        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hw/rtl/lr1pe_pkg.sv
hw/rtl/lr1pe_ram.sv
hw/rtl/lr1pe_datapath.sv
hw/rtl/lr1pe_ctrl.sv
hw/rtl/lr1_parse_engine_top.sv
bench/lr1_parse_engine_top_test.sv
